FILE: rtl/core/bsm3_pkg.sv
package bsm3_pkg;

   // configuration register indexes
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_TAP_WEIGHT   = 2'd2;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 13;

   // register reset values
   localparam logic [11:0] IMAGE_WIDTH_RESET  = 12'd640;
   localparam logic [12:0] IMAGE_HEIGHT_RESET = 13'd480;
   localparam logic [9:0]  TAP_WEIGHT_RESET   = 10'd123;

   // nine 8-bit taps fit in 12 bits, weight is q0.10
   localparam int SUM_WIDTH    = 12;
   localparam int WEIGHT_WIDTH = 10;
   localparam int PROD_WIDTH   = SUM_WIDTH + WEIGHT_WIDTH;
   localparam int MIN_DIM      = 3;

   typedef struct packed {
      logic [7:0] gray_pixel;
      logic       frame_start;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  smoothed_pixel;
      logic [11:0] centre_row;
      logic [10:0] centre_col;
      logic        clipped;
      logic        frame_last;
   } rsp_payload_type;

endpackage

FILE: rtl/core/box_smooth_3x3.sv
// channel   direction  handshake                 payload
// req       in         req_valid / req_stall     req_payload_type  (gray_pixel, frame_start)
// rsp       out        rsp_valid / rsp_stall     rsp_payload_type  (smoothed_pixel, centre_row,
//                                                centre_col, clipped, frame_last)
// csr       in         csr_write_enable          csr_index, csr_write_data
//
// one pixel transfer per clock while req_stall is low; each result is registered through
// stage a (line store read), stage b (window sum) and the output register (weight multiply)
// after reset a clearing pass zeroes every column of both line stores with req_stall high
// a two-entry output (register plus skid) keeps the pipeline running while rsp is stalled;
// req_stall rises only once the skid entry is occupied
// border pixels give no result, so rsp carries fewer transfers than req
module box_smooth_3x3
   import bsm3_pkg::*;
#(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_payload_type            req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_payload_type            rsp_payload,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   // column and row counter widths
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RW = $clog2(MAX_HEIGHT);
   // compare widths for geometry limiting
   localparam int WXW = (CW + 1 > 12) ? CW + 1 : 12;
   localparam int HXW = (RW + 1 > 13) ? RW + 1 : 13;

   // configuration registers
   logic [11:0]             image_width_ff;
   logic [12:0]             image_height_ff;
   logic [WEIGHT_WIDTH-1:0] tap_weight_ff;

   // line stores
   logic [7:0] line_upper [MAX_WIDTH];
   logic [7:0] line_middle [MAX_WIDTH];

   // clearing pass
   logic          clr_ff, clr_in;
   logic [CW-1:0] clr_addr_ff, clr_addr_in;

   // position
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   // stage a: pixel plus line store read data
   logic          valid_a_ff, valid_a_in;
   logic [7:0]    pix_a_ff;
   logic [CW-1:0] col_a_ff;
   logic [RW-1:0] row_a_ff;
   logic          emit_a_ff, last_a_ff;
   logic [7:0]    rd_up_ff, rd_mid_ff;
   logic          fwd_ff, fwd_in;
   logic [7:0]    fwd_up_ff, fwd_mid_ff;

   // window, entries 0..2 column c-1, 3..5 column c-2
   logic [7:0] win_ff [6];

   // stage b: window sum
   logic                 valid_b_ff, valid_b_in;
   logic [SUM_WIDTH-1:0] sum_b_ff;
   logic [11:0]          centre_row_b_ff;
   logic [10:0]          centre_col_b_ff;
   logic                 last_b_ff;

   // output register and skid
   logic            rsp_valid_ff, rsp_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type rsp_payload_ff, skid_payload_ff;

   logic            en;
   logic            req_accept;
   logic            rsp_take;
   logic [CW:0]     w_lim;
   logic [RW:0]     h_lim;
   logic [WXW-1:0]  w_ext;
   logic [HXW-1:0]  h_ext;
   logic [CW-1:0]   c_cur;
   logic [RW-1:0]   r_cur;
   logic            emit_cur, last_cur;
   logic [7:0]      up_eff, mid_eff;
   logic            mem_we;
   logic [CW-1:0]   mem_waddr;
   logic [7:0]      mem_wup, mem_wmid;
   logic [SUM_WIDTH-1:0]  sum_in;
   logic [PROD_WIDTH-1:0] prod;
   logic [SUM_WIDTH-1:0]  scaled;
   rsp_payload_type       result;

   // pipeline moves whenever the skid entry is free
   assign en         = !skid_valid_ff;
   assign req_stall  = clr_ff || skid_valid_ff;
   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;

   // geometry limited to 3..MAX
   always_comb begin
      w_ext = WXW'(image_width_ff);
      h_ext = HXW'(image_height_ff);
      if (w_ext < WXW'(MIN_DIM)) begin
         w_lim = (CW + 1)'(MIN_DIM);
      end else if (w_ext > WXW'(MAX_WIDTH)) begin
         w_lim = (CW + 1)'(MAX_WIDTH);
      end else begin
         w_lim = (CW + 1)'(w_ext);
      end
      if (h_ext < HXW'(MIN_DIM)) begin
         h_lim = (RW + 1)'(MIN_DIM);
      end else if (h_ext > HXW'(MAX_HEIGHT)) begin
         h_lim = (RW + 1)'(MAX_HEIGHT);
      end else begin
         h_lim = (RW + 1)'(h_ext);
      end
   end

   // position of the incoming pixel, frame_start restarts at the origin
   always_comb begin
      c_cur = req_payload.frame_start ? '0 : col_ff;
      r_cur = req_payload.frame_start ? '0 : row_ff;
      emit_cur = (r_cur >= RW'(MIN_DIM)) && ({1'b0, r_cur} < h_lim)
              && (c_cur >= CW'(MIN_DIM)) && ({1'b0, c_cur} < w_lim);
      last_cur = ({1'b0, r_cur} == h_lim - 1'b1) && ({1'b0, c_cur} == w_lim - 1'b1);
      col_in = col_ff;
      row_in = row_ff;
      if (req_accept) begin
         if ({1'b0, c_cur} + 1'b1 >= w_lim) begin
            col_in = '0;
            row_in = ({1'b0, r_cur} + 1'b1 >= h_lim) ? '0 : r_cur + 1'b1;
         end else begin
            col_in = c_cur + 1'b1;
            row_in = r_cur;
         end
      end
   end

   // line store taps, bypassed when the previous pixel wrote the same column
   assign up_eff  = fwd_ff ? fwd_up_ff : rd_up_ff;
   assign mid_eff = fwd_ff ? fwd_mid_ff : rd_mid_ff;

   always_comb begin
      fwd_in = fwd_ff;
      if (req_accept) begin
         fwd_in = valid_a_ff && (col_a_ff == c_cur);
      end
   end

   // clearing pass after reset
   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == CW'(MAX_WIDTH - 1)) begin
            clr_in = 1'b0;
         end
      end
   end

   // line store write: clearing, or the pixel leaving stage a
   always_comb begin
      mem_we    = clr_ff || (en && valid_a_ff);
      mem_waddr = clr_ff ? clr_addr_ff : col_a_ff;
      mem_wup   = clr_ff ? 8'd0 : mid_eff;
      mem_wmid  = clr_ff ? 8'd0 : pix_a_ff;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_upper[mem_waddr]  <= mem_wup;
         line_middle[mem_waddr] <= mem_wmid;
      end
      if (req_accept) begin
         rd_up_ff  <= line_upper[c_cur];
         rd_mid_ff <= line_middle[c_cur];
      end
   end

   // nine-tap sum
   assign sum_in = SUM_WIDTH'(up_eff) + SUM_WIDTH'(mid_eff) + SUM_WIDTH'(pix_a_ff)
                 + SUM_WIDTH'(win_ff[0]) + SUM_WIDTH'(win_ff[1]) + SUM_WIDTH'(win_ff[2])
                 + SUM_WIDTH'(win_ff[3]) + SUM_WIDTH'(win_ff[4]) + SUM_WIDTH'(win_ff[5]);

   // weight, drop the fraction, saturate
   always_comb begin
      prod   = PROD_WIDTH'(sum_b_ff) * PROD_WIDTH'(tap_weight_ff);
      scaled = prod[PROD_WIDTH-1:WEIGHT_WIDTH];
      result.clipped        = |scaled[SUM_WIDTH-1:8];
      result.smoothed_pixel = result.clipped ? 8'hff : scaled[7:0];
      result.centre_row     = centre_row_b_ff;
      result.centre_col     = centre_col_b_ff;
      result.frame_last     = last_b_ff;
   end

   // stage valids
   always_comb begin
      valid_a_in = valid_a_ff;
      valid_b_in = valid_b_ff;
      if (en) begin
         valid_a_in = req_accept;
         valid_b_in = valid_a_ff && emit_a_ff;
      end
   end

   // output register and skid entry
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_take) begin
            skid_valid_in = 1'b0;
         end
      end else if (valid_b_ff) begin
         if (rsp_valid_ff && !rsp_take) begin
            skid_valid_in = 1'b1;
         end else begin
            rsp_valid_in = 1'b1;
         end
      end else if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= IMAGE_WIDTH_RESET;
         image_height_ff <= IMAGE_HEIGHT_RESET;
         tap_weight_ff   <= TAP_WEIGHT_RESET;
         clr_ff          <= 1'b1;
         clr_addr_ff     <= '0;
         col_ff          <= '0;
         row_ff          <= '0;
         valid_a_ff      <= 1'b0;
         valid_b_ff      <= 1'b0;
         fwd_ff          <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= 8'd0;
         end
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  image_width_ff  <= csr_write_data[11:0];
               CSR_IMAGE_HEIGHT: image_height_ff <= csr_write_data[12:0];
               CSR_TAP_WEIGHT:   tap_weight_ff   <= csr_write_data[WEIGHT_WIDTH-1:0];
               default: ;
            endcase
         end
         clr_ff        <= clr_in;
         clr_addr_ff   <= clr_addr_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         valid_a_ff    <= valid_a_in;
         valid_b_ff    <= valid_b_in;
         fwd_ff        <= fwd_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
         // window shifts with every pixel leaving stage a
         if (en && valid_a_ff) begin
            win_ff[3] <= win_ff[0];
            win_ff[4] <= win_ff[1];
            win_ff[5] <= win_ff[2];
            win_ff[0] <= up_eff;
            win_ff[1] <= mid_eff;
            win_ff[2] <= pix_a_ff;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         pix_a_ff   <= req_payload.gray_pixel;
         col_a_ff   <= c_cur;
         row_a_ff   <= r_cur;
         emit_a_ff  <= emit_cur;
         last_a_ff  <= last_cur;
         fwd_up_ff  <= mid_eff;
         fwd_mid_ff <= pix_a_ff;
      end
      if (en && valid_a_ff) begin
         sum_b_ff        <= sum_in;
         centre_row_b_ff <= 12'(row_a_ff - RW'(1));
         centre_col_b_ff <= 11'(col_a_ff - CW'(1));
         last_b_ff       <= last_a_ff;
      end
      if (skid_valid_ff) begin
         if (rsp_take) begin
            rsp_payload_ff <= skid_payload_ff;
         end
      end else if (valid_b_ff) begin
         if (rsp_valid_ff && !rsp_take) begin
            skid_payload_ff <= result;
         end else begin
            rsp_payload_ff <= result;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // skid fills only while the output register is held
   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid entry filled without a held output");

   // an occupied skid always sits behind a valid output
   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry occupied with empty output register");

   // clearing pass ends only after the last column
   a_clear_len: assert property (@(posedge clock) disable iff (reset)
      $fell(clr_ff) |-> ($past(clr_addr_ff) == CW'(MAX_WIDTH - 1)))
      else $error("clearing pass ended early");

   // only interior centres reach the sum stage as results
   a_emit_interior: assert property (@(posedge clock) disable iff (reset)
      (valid_a_ff && emit_a_ff) |-> (col_a_ff >= CW'(MIN_DIM) && row_a_ff >= RW'(MIN_DIM)))
      else $error("border pixel marked for output");

   // no pixel transfer during the clearing pass
   a_clear_block: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> !valid_a_ff)
      else $error("pixel in flight during clearing pass");

endmodule
